// ===== rtl/sef_pkg.sv =====
// shared constants, payload types and lane control types for the stereo echo comb filter
package sef_pkg;

   localparam int DELAY_DEPTH    = 65536;
   localparam int GAIN_FRAC_BITS = 12;

   localparam int SAMPLE_W  = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam int ADDR_W = $clog2(DELAY_DEPTH);
   // wide enough for the delay register and for the memory depth itself
   localparam int DLY_W  = ((ADDR_W + 1) > CSR_W) ? (ADDR_W + 1) : CSR_W;
   localparam int PROD_W = SAMPLE_W + CSR_W + 1;
   localparam int SUM_W  = PROD_W + 1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_DELAY_SAMPLES = csr_index_type'(0);
   localparam csr_index_type REG_ECHO_GAIN     = csr_index_type'(1);

   localparam logic [CSR_W-1:0] DELAY_RESET = CSR_W'(22050);
   localparam logic [CSR_W-1:0] GAIN_RESET  = CSR_W'(2048);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic                       drain;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       clipped;
   } rsp_payload_type;

   typedef struct packed {
      logic              accept;
      logic              advance;
      logic              echo_ok;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clip;
   } lane_result_type;

endpackage

// ===== rtl/sef_lane.sv =====
// one channel lane: delay memory, echo gain multiply, round toward zero and saturating add
module sef_lane import sef_pkg::*; (
   input  logic                       clock,
   input  lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic [CSR_W-1:0]           gain,
   output lane_result_type            result
);

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << GAIN_FRAC_BITS) - 1);
   localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0]  SAT_MIN    = SUM_W'(-32768);

   logic signed [SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];

   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SAMPLE_W-1:0] x1_ff;
   logic                       ok1_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [SAMPLE_W-1:0] x2_ff;

   logic signed [SAMPLE_W-1:0] echo;
   logic signed [PROD_W-1:0]   echo_ext;
   logic signed [PROD_W-1:0]   gain_ext;
   logic signed [PROD_W-1:0]   biased;
   logic signed [PROD_W-1:0]   scaled;
   logic signed [SUM_W-1:0]    sum;

   // read before write, so a full-depth delay still sees the oldest sample
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         rd_data_ff                <= delay_mem[ctrl.rd_addr];
         delay_mem[ctrl.wr_addr]   <= sample_in;
         x1_ff                     <= sample_in;
         ok1_ff                    <= ctrl.echo_ok;
      end
   end

   // entries not yet written since reset read as zero
   assign echo     = ok1_ff ? rd_data_ff : '0;
   assign echo_ext = PROD_W'(echo);
   assign gain_ext = signed'(PROD_W'({1'b0, gain}));
   assign prod_in  = echo_ext * gain_ext;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff <= prod_in;
         x2_ff   <= x1_ff;
      end
   end

   // truncate toward zero: bias negative products before the arithmetic shift
   assign biased = prod_ff[PROD_W-1] ? (prod_ff + ROUND_BIAS) : prod_ff;
   assign scaled = biased >>> GAIN_FRAC_BITS;
   assign sum    = SUM_W'(scaled) + SUM_W'(x2_ff);

   always_comb begin
      if (sum > SAT_MAX) begin
         result.sample = SAT_MAX[SAMPLE_W-1:0];
         result.clip   = 1'b1;
      end else if (sum < SAT_MIN) begin
         result.sample = SAT_MIN[SAMPLE_W-1:0];
         result.clip   = 1'b1;
      end else begin
         result.sample = sum[SAMPLE_W-1:0];
         result.clip   = 1'b0;
      end
   end

endmodule

// ===== rtl/sef_merge.sv =====
// merge stage: joins the two lane results into the registered result beat
module sef_merge import sef_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            lane_valid,
   input  lane_result_type left_result,
   input  lane_result_type right_result,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   assign rsp_valid_in = advance ? lane_valid : rsp_valid_ff;

   always_comb begin
      rsp_data_in.left_out  = left_result.sample;
      rsp_data_in.right_out = right_result.sample;
      rsp_data_in.clipped   = left_result.clip | right_result.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/stereo_echo_comb_filter.sv =====
// Stereo feedforward comb filter: each beat carries one left/right sample pair and returns
// x + gain * x delayed, saturated to 16 bits, for both channels. One beat is accepted every
// clock while the result register is not held by rsp_stall; each result goes through the
// delay memory read at the accepting edge, the multiply register, then add and saturate
// into the output register. The rate is set by the delay memory of each lane, which takes
// one read and one write per beat. When the result register is held by rsp_stall the whole
// pipeline freezes and req_stall rises in the same cycle. There is no clearing pass after
// reset: a fill flag and the write pointer tell which entries have been written, and
// unwritten entries read as zero, so the block takes beats right after reset.
// Registers (csr_index): 0 delay_samples (0 acts as 1), 1 echo_gain (unsigned Q4.12).
module stereo_echo_comb_filter import sef_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DELAY_DEPTH - 1);
   localparam logic [DLY_W-1:0]  DEPTH_EXT = DLY_W'(DELAY_DEPTH);
   localparam logic [DLY_W-1:0]  ONE_EXT   = DLY_W'(1);

   logic [CSR_W-1:0]  delay_ff;
   logic [CSR_W-1:0]  delay_in;
   logic [CSR_W-1:0]  gain_ff;
   logic [CSR_W-1:0]  gain_in;
   logic [ADDR_W-1:0] wp_ff;
   logic [ADDR_W-1:0] wp_in;
   logic              full_ff;
   logic              full_in;
   logic              v1_ff;
   logic              v1_in;
   logic              v2_ff;
   logic              v2_in;

   logic              advance;
   logic              accept;
   logic [DLY_W-1:0]  dly_raw;
   logic [DLY_W-1:0]  dly_eff;
   logic [DLY_W-1:0]  wp_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic              echo_ok;

   logic signed [SAMPLE_W-1:0] left_x;
   logic signed [SAMPLE_W-1:0] right_x;
   lane_ctrl_type              lane_ctrl;
   lane_result_type            left_result;
   lane_result_type            right_result;

   // csr writes
   always_comb begin
      delay_in = delay_ff;
      gain_in  = gain_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DELAY_SAMPLES: delay_in = csr_wdata;
            REG_ECHO_GAIN:     gain_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline moves as one unit whenever the output register can take a beat
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign dly_raw = DLY_W'(delay_ff);
   always_comb begin
      if (dly_raw == '0) begin
         dly_eff = ONE_EXT;
      end else if (dly_raw > DEPTH_EXT) begin
         dly_eff = DEPTH_EXT;
      end else begin
         dly_eff = dly_raw;
      end
   end

   assign wp_ext  = DLY_W'(wp_ff);
   assign rd_addr = (wp_ext >= dly_eff) ? ADDR_W'(wp_ext - dly_eff)
                                        : ADDR_W'(wp_ext + DEPTH_EXT - dly_eff);
   // before the first wrap only addresses below the write pointer hold samples
   assign echo_ok = full_ff || (wp_ext >= dly_eff);

   assign wp_in   = accept ? ((wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1) : wp_ff;
   assign full_in = full_ff || (accept && (wp_ff == LAST_ADDR));
   assign v1_in   = advance ? accept : v1_ff;
   assign v2_in   = advance ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         gain_ff  <= GAIN_RESET;
         wp_ff    <= '0;
         full_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         delay_ff <= delay_in;
         gain_ff  <= gain_in;
         wp_ff    <= wp_in;
         full_ff  <= full_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
   end

   assign left_x  = req_data.drain ? '0 : req_data.left_in;
   assign right_x = req_data.drain ? '0 : req_data.right_in;

   always_comb begin
      lane_ctrl.accept  = accept;
      lane_ctrl.advance = advance;
      lane_ctrl.echo_ok = echo_ok;
      lane_ctrl.wr_addr = wp_ff;
      lane_ctrl.rd_addr = rd_addr;
   end

   sef_lane u_left_lane (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sample_in (left_x),
      .gain      (gain_ff),
      .result    (left_result)
   );

   sef_lane u_right_lane (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sample_in (right_x),
      .gain      (gain_ff),
      .result    (right_result)
   );

   sef_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .lane_valid   (v2_ff),
      .left_result  (left_result),
      .right_result (right_result),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // once the memory has wrapped every entry stays valid
   assert property (@(posedge clock) disable iff (reset) full_ff |=> full_ff)
      else $error("fill flag dropped after wrap");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (wp_ff == LAST_ADDR)) |=> (full_ff && (wp_ff == '0)))
      else $error("write pointer wrap not tracked");

   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(v2_ff))
      else $error("result beat without a beat in the multiply stage");

   assert property (@(posedge clock) disable iff (reset) req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output register is free");

   assert property (@(posedge clock) disable iff (reset)
      (!advance && v1_ff) |=> (v1_ff && $stable(wp_ff)))
      else $error("pipeline moved while frozen");

endmodule
